/* design/ltq_pkg.sv */
package ltq_pkg;

    localparam int NUM_TASKS = 16;
    localparam int TASK_W    = $clog2(NUM_TASKS);
    localparam int CNT_W     = $clog2(NUM_TASKS + 1);

    localparam logic [1:0] FUNC_PUSH   = 2'd0;
    localparam logic [1:0] FUNC_POP    = 2'd1;
    localparam logic [1:0] FUNC_REMOVE = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_DUP    = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] task_id;
    } req_t;

    typedef struct packed {
        logic [3:0] out_task;
        logic       out_valid;
        logic [1:0] status;
        logic       queue_empty;
        logic [4:0] entry_total;
    } rsp_t;

endpackage

/* design/ltq_in_reg.sv */
module ltq_in_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ltq_pkg::req_t req,
    input  logic          advance,
    output logic          hold_valid,
    output ltq_pkg::req_t hold
);

    logic          valid_reg;
    logic          valid_next;
    ltq_pkg::req_t data_reg;

    // held transaction leaves whenever the output side can take it
    assign req_ready  = !valid_reg || advance;
    assign valid_next = req_ready ? req_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && req_ready)
        begin
            data_reg <= req;
        end
    end

    assign hold_valid = valid_reg;
    assign hold       = data_reg;

endmodule

/* design/ltq_core.sv */
module ltq_core
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  ltq_pkg::req_t req,
    output ltq_pkg::rsp_t rsp
);

    logic [ltq_pkg::TASK_W-1:0]    head_reg, head_next;
    logic [ltq_pkg::TASK_W-1:0]    tail_reg, tail_next;
    logic [ltq_pkg::CNT_W-1:0]     count_reg, count_next;
    logic [ltq_pkg::NUM_TASKS-1:0] in_queue_reg, in_queue_next;
    logic [ltq_pkg::TASK_W-1:0]    next_link_reg [ltq_pkg::NUM_TASKS];
    logic [ltq_pkg::TASK_W-1:0]    prev_link_reg [ltq_pkg::NUM_TASKS];

    logic [ltq_pkg::TASK_W-1:0] t;
    logic [ltq_pkg::TASK_W-1:0] nx_addr;
    logic [ltq_pkg::TASK_W-1:0] nx;
    logic [ltq_pkg::TASK_W-1:0] pv;
    logic                       member;
    logic                       empty;
    logic                       is_head;
    logic                       is_tail;

    logic                       nl_we, pl_we;
    logic [ltq_pkg::TASK_W-1:0] nl_addr, nl_data;
    logic [ltq_pkg::TASK_W-1:0] pl_addr, pl_data;

    assign t       = req.task_id;
    assign member  = in_queue_reg[t];
    assign empty   = (count_reg == '0);
    assign is_head = (t == head_reg);
    assign is_tail = (t == tail_reg);
    // pop follows the head, remove follows the named slot
    assign nx_addr = (req.func == ltq_pkg::FUNC_POP) ? head_reg : t;
    assign nx      = next_link_reg[nx_addr];
    assign pv      = prev_link_reg[t];

    always_comb
    begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        count_next    = count_reg;
        in_queue_next = in_queue_reg;
        nl_we         = 1'b0;
        nl_addr       = tail_reg;
        nl_data       = t;
        pl_we         = 1'b0;
        pl_addr       = t;
        pl_data       = tail_reg;
        rsp.out_task  = '0;
        rsp.out_valid = 1'b0;
        rsp.status    = ltq_pkg::ST_OK;

        case (req.func)
            ltq_pkg::FUNC_PUSH:
            begin
                if (member)
                begin
                    rsp.status = ltq_pkg::ST_DUP;
                end
                else
                begin
                    if (empty)
                    begin
                        head_next = t;
                    end
                    else
                    begin
                        nl_we = 1'b1;
                        pl_we = 1'b1;
                    end
                    tail_next        = t;
                    in_queue_next[t] = 1'b1;
                    count_next       = count_reg + ltq_pkg::CNT_W'(1);
                end
            end
            ltq_pkg::FUNC_POP:
            begin
                if (empty)
                begin
                    rsp.status = ltq_pkg::ST_EMPTY;
                end
                else
                begin
                    rsp.out_task  = head_reg;
                    rsp.out_valid = 1'b1;
                    if (count_reg > ltq_pkg::CNT_W'(1))
                    begin
                        head_next = nx;
                    end
                    in_queue_next[head_reg] = 1'b0;
                    count_next              = count_reg - ltq_pkg::CNT_W'(1);
                end
            end
            ltq_pkg::FUNC_REMOVE:
            begin
                if (!member)
                begin
                    rsp.status = ltq_pkg::ST_ABSENT;
                end
                else
                begin
                    if (is_head && is_tail)
                    begin
                        head_next = head_reg;
                    end
                    else if (is_head)
                    begin
                        head_next = nx;
                    end
                    else if (is_tail)
                    begin
                        tail_next = pv;
                    end
                    else
                    begin
                        // unlink a middle slot
                        nl_we   = 1'b1;
                        nl_addr = pv;
                        nl_data = nx;
                        pl_we   = 1'b1;
                        pl_addr = nx;
                        pl_data = pv;
                    end
                    in_queue_next[t] = 1'b0;
                    count_next       = count_reg - ltq_pkg::CNT_W'(1);
                    rsp.out_valid    = !is_tail;
                    rsp.out_task     = is_tail ? '0 : nx;
                end
            end
            default:
            begin
                rsp.status = ltq_pkg::ST_OK;
            end
        endcase

        rsp.queue_empty = (count_next == '0);
        rsp.entry_total = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            in_queue_reg <= '0;
        end
        else if (fire)
        begin
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            in_queue_reg <= in_queue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && nl_we)
        begin
            next_link_reg[nl_addr] <= nl_data;
        end
        if (fire && pl_we)
        begin
            prev_link_reg[pl_addr] <= pl_data;
        end
    end

endmodule

/* design/ltq_out_reg.sv */
module ltq_out_reg
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  ltq_pkg::rsp_t rsp_in,
    output logic          advance,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ltq_pkg::rsp_t rsp
);

    logic          valid_reg;
    logic          valid_next;
    ltq_pkg::rsp_t data_reg;

    assign advance    = !valid_reg || rsp_ready;
    assign valid_next = advance ? load : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && advance)
        begin
            data_reg <= rsp_in;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = data_reg;

endmodule

/* design/linked_task_queue_top.sv */
// Task queue over 16 task slots, kept as a doubly linked list.
// Request channel (req_valid/req_ready/req): func selects push at tail, pop
// head, or remove the slot in task_id from anywhere in the list.
// Response channel (rsp_valid/rsp_ready/rsp): one transaction per request,
// in request order, with the popped task or the follower of a removed task,
// a status code, the empty flag and the entry count after the operation.
// A request accepted into the request register moves on into the response
// register when advance allows, and rsp_valid rises as it loads.
// Throughput: one request per cycle while rsp_ready is high; list update is
// one pass of logic between the request register and the response register,
// reading and writing at most two entries of each link array per operation.
// When rsp_ready is low the response register holds; the request register
// still takes one more transaction, then req_ready drops until rsp drains.
// Reset (rst_n, async, active low) empties the queue: head, tail, count and
// all membership bits clear; link entries are left as they are and are only
// read for queued slots. No clearing pass is needed after reset.
module linked_task_queue_top
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ltq_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ltq_pkg::rsp_t rsp
);

    logic          hold_valid;
    ltq_pkg::req_t hold;
    logic          advance;
    logic          fire;
    ltq_pkg::rsp_t core_rsp;

    assign fire = hold_valid && advance;

    ltq_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold       (hold)
    );

    ltq_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (hold),
        .rsp   (core_rsp)
    );

    ltq_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (hold_valid),
        .rsp_in    (core_rsp),
        .advance   (advance),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    a_empty_matches_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.queue_empty == (rsp.entry_total == '0)))
        else $error("empty flag disagrees with entry count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.entry_total <= ltq_pkg::CNT_W'(ltq_pkg::NUM_TASKS)))
        else $error("entry count beyond pool size");

    a_task_only_on_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.out_valid) |-> (rsp.status == ltq_pkg::ST_OK))
        else $error("task returned with error status");

    a_empty_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ltq_pkg::ST_EMPTY) |-> (rsp.entry_total == '0))
        else $error("pop-on-empty reported with nonzero count");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps

module tb;

    // no named code for the spare operation; the block treats it as a no-op
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    class task_list_scoreboard;
        logic [ltq_pkg::TASK_W-1:0]    head_task = '0;
        logic [ltq_pkg::TASK_W-1:0]    tail_task = '0;
        logic [ltq_pkg::TASK_W-1:0]    next_of [ltq_pkg::NUM_TASKS];
        logic [ltq_pkg::TASK_W-1:0]    prev_of [ltq_pkg::NUM_TASKS];
        bit   [ltq_pkg::NUM_TASKS-1:0] queued = '0;
        int unsigned                   total = 0;
        ltq_pkg::rsp_t                 predicted_rsp [$];
        int                            errors = 0;

        // advance the list model by one request and queue the response it implies
        function void note_request(ltq_pkg::req_t r);
            ltq_pkg::rsp_t              o;
            logic [ltq_pkg::TASK_W-1:0] id;
            logic [ltq_pkg::TASK_W-1:0] nx;
            logic [ltq_pkg::TASK_W-1:0] pv;
            bit                         at_tail;
            o = '0;
            id = r.task_id;
            o.status = ltq_pkg::ST_OK;
            case (r.func)
                ltq_pkg::FUNC_PUSH:
                begin
                    if (int'(id) >= ltq_pkg::NUM_TASKS)
                        o.status = ltq_pkg::ST_ABSENT;
                    else if (queued[id])
                        o.status = ltq_pkg::ST_DUP;
                    else
                    begin
                        if (total == 0)
                            head_task = id;
                        else
                        begin
                            next_of[tail_task] = id;
                            prev_of[id] = tail_task;
                        end
                        tail_task = id;
                        queued[id] = 1'b1;
                        total++;
                    end
                end
                ltq_pkg::FUNC_POP:
                begin
                    if (total == 0)
                        o.status = ltq_pkg::ST_EMPTY;
                    else
                    begin
                        o.out_task = head_task;
                        o.out_valid = 1'b1;
                        queued[head_task] = 1'b0;
                        if (total > 1)
                            head_task = next_of[head_task];
                        total--;
                    end
                end
                ltq_pkg::FUNC_REMOVE:
                begin
                    if (int'(id) >= ltq_pkg::NUM_TASKS || !queued[id])
                        o.status = ltq_pkg::ST_ABSENT;
                    else
                    begin
                        at_tail = (id == tail_task);
                        nx = next_of[id];
                        pv = prev_of[id];
                        if (id == head_task && at_tail)
                            ;
                        else if (id == head_task)
                            head_task = nx;
                        else if (at_tail)
                            tail_task = pv;
                        else
                        begin
                            next_of[pv] = nx;
                            prev_of[nx] = pv;
                        end
                        queued[id] = 1'b0;
                        total--;
                        if (!at_tail)
                        begin
                            o.out_task = nx;
                            o.out_valid = 1'b1;
                        end
                    end
                end
                default:
                    ;
            endcase
            o.queue_empty = (total == 0);
            o.entry_total = total[ltq_pkg::CNT_W-1:0];
            predicted_rsp.push_back(o);
        endfunction

        function void compare_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
            if (exp_val !== act_val)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_response(ltq_pkg::rsp_t got);
            ltq_pkg::rsp_t exp_rsp;
            if (predicted_rsp.size() == 0)
            begin
                $error("response transaction with nothing outstanding: %p", got);
                errors++;
                return;
            end
            exp_rsp = predicted_rsp.pop_front();
            compare_field("out_task", exp_rsp.out_task, got.out_task);
            compare_field("out_valid", exp_rsp.out_valid, got.out_valid);
            compare_field("status", exp_rsp.status, got.status);
            compare_field("queue_empty", exp_rsp.queue_empty, got.queue_empty);
            compare_field("entry_total", exp_rsp.entry_total, got.entry_total);
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    ltq_pkg::req_t req;
    logic          rsp_valid;
    logic          rsp_ready;
    ltq_pkg::rsp_t rsp;

    int send_idle_pct;
    int recv_idle_pct;

    task_list_scoreboard sb;

    linked_task_queue_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_request(req);
            if (rsp_valid && rsp_ready)
                sb.check_response(rsp);
        end
    end

    always @(negedge clk)
        rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    function automatic ltq_pkg::req_t make_req(logic [1:0] f, logic [3:0] t);
        ltq_pkg::req_t r;
        r.func = f;
        r.task_id = t;
        return r;
    endfunction

    // random slot with the wanted membership, or any slot if none qualifies
    function automatic logic [3:0] pick_slot(bit want_queued);
        logic [3:0] cands [$];
        for (int i = 0; i < ltq_pkg::NUM_TASKS; i++)
            if (sb.queued[i] == want_queued)
                cands.push_back(i[3:0]);
        if (cands.size() == 0)
            return 4'($urandom_range(0, ltq_pkg::NUM_TASKS - 1));
        return cands[$urandom_range(0, cands.size() - 1)];
    endfunction

    // push_pct/pop_pct shape whether the list tends to fill or drain
    function automatic ltq_pkg::req_t random_req(int push_pct, int pop_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if ($urandom_range(0, 99) < 2)
            return make_req(FUNC_SPARE, 4'($urandom()));
        if (roll < push_pct)
            return make_req(ltq_pkg::FUNC_PUSH,
                            ($urandom_range(0, 99) < 85) ? pick_slot(1'b0)
                                                         : 4'($urandom()));
        if (roll < push_pct + pop_pct)
            return make_req(ltq_pkg::FUNC_POP, 4'($urandom()));
        return make_req(ltq_pkg::FUNC_REMOVE,
                        ($urandom_range(0, 99) < 85) ? pick_slot(1'b1)
                                                     : 4'($urandom()));
    endfunction

    task automatic send_request(ltq_pkg::req_t r);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    initial
    begin
        int push_pct;
        int pop_pct;
        sb = new;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        send_idle_pct = 14;
        recv_idle_pct = 46;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: empty-queue errors, duplicates, removal at head/middle/tail
        send_request(make_req(ltq_pkg::FUNC_POP, 4'd0));
        send_request(make_req(ltq_pkg::FUNC_REMOVE, 4'd5));
        send_request(make_req(FUNC_SPARE, 4'hF));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd0));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd15));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd0));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd7));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd8));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd3));
        send_request(make_req(ltq_pkg::FUNC_REMOVE, 4'd7));
        send_request(make_req(ltq_pkg::FUNC_REMOVE, 4'd3));
        send_request(make_req(ltq_pkg::FUNC_REMOVE, 4'd0));
        send_request(make_req(ltq_pkg::FUNC_REMOVE, 4'd3));
        send_request(make_req(FUNC_SPARE, 4'd10));
        send_request(make_req(ltq_pkg::FUNC_POP, 4'd0));
        send_request(make_req(ltq_pkg::FUNC_POP, 4'd0));
        send_request(make_req(ltq_pkg::FUNC_POP, 4'hF));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd10));
        send_request(make_req(ltq_pkg::FUNC_REMOVE, 4'd10));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd5));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd10));
        send_request(make_req(ltq_pkg::FUNC_PUSH, 4'd12));
        send_request(make_req(ltq_pkg::FUNC_REMOVE, 4'd10));
        send_request(make_req(ltq_pkg::FUNC_POP, 4'd0));
        send_request(make_req(ltq_pkg::FUNC_POP, 4'd0));

        push_pct = 50;
        pop_pct = 25;
        for (int i = 0; i < 1400; i++)
        begin
            if (i == 467)
            begin
                send_idle_pct = 46;
                recv_idle_pct = 14;
            end
            else if (i == 934)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // change bias every 40 transactions: fill, drain or balanced
            if (i % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0:
                    begin
                        push_pct = 75;
                        pop_pct = 12;
                    end
                    1:
                    begin
                        push_pct = 20;
                        pop_pct = 40;
                    end
                    default:
                    begin
                        push_pct = 45;
                        pop_pct = 27;
                    end
                endcase
            end
            send_request(random_req(push_pct, pop_pct));
        end

        @(negedge clk);
        req_valid <= 1'b0;
        while (sb.predicted_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

/* filelist.f */
design/ltq_pkg.sv
design/ltq_in_reg.sv
design/ltq_core.sv
design/ltq_out_reg.sv
design/linked_task_queue_top.sv
test/tb.sv
